/* rtl/sbgr_pkg.sv */
`timescale 1ns / 1ps
// Shared constants for the scaled bitmap glyph rasteriser.
// No dependencies; used by scaled_bitmap_glyph_rasterizer_top.
package sbgr_pkg;

  localparam int GlyphRows = 16;
  localparam int FontBytes = 4096;

  localparam int MaxWidth  = 32;
  localparam int ByteW     = 8;

  localparam int InDataW   = 72;
  localparam int OutDataW  = 96;

  localparam logic OpLoad = 1'b0;
  localparam logic OpDraw = 1'b1;

endpackage

/* rtl/sbgr_ram.sv */
`timescale 1ns / 1ps
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module sbgr_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/scaled_bitmap_glyph_rasterizer_top.sv */
`timescale 1ns / 1ps
// Scaled bitmap glyph rasteriser: font memory loader and 1x/2x row blitter.
// Depends on sbgr_pkg and sbgr_ram.
//
//  channel  dir  beat                     tuser    tlast
//  s_axis   in   load byte or draw glyph  opcode   -
//  m_axis   out  one scaled glyph row     -        last_row
//
// A load wraps its address by subtracting FONT_BYTES until it is in range,
// then writes the byte. A draw takes the same wrap, then per source row reads
// ceil(width/8) font bytes on the single RAM port and emits 1 or 2 rows (each
// waits on m_axis_tready). The next beat is taken while the last row waits.
// Reset clears control state only; font memory is undefined until loaded.
module scaled_bitmap_glyph_rasterizer_top #(
  parameter int GLYPH_ROWS = sbgr_pkg::GlyphRows,
  parameter int FONT_BYTES = sbgr_pkg::FontBytes
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // font_address, font_byte, glyph_offset, glyph_width, origin_x, origin_y,
  // color, scale
  input  logic [sbgr_pkg::InDataW-1:0]  s_axis_tdata,
  // opcode
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // row_y, row_x, pixel_color, pixel_mask
  output logic [sbgr_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                          m_axis_tlast
);

  localparam int AW = (FONT_BYTES > 1) ? $clog2(FONT_BYTES) : 1;
  localparam int PW = (AW > 12) ? AW : 12;
  localparam int RW = $clog2(2 * GLYPH_ROWS);
  localparam int SW = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;
  localparam logic [PW:0]   FB      = (PW + 1)'(FONT_BYTES);
  localparam logic [SW-1:0] LastSrc = SW'(GLYPH_ROWS - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WRAP = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [PW-1:0] ptr_q, ptr_d, ptr_inc;
  logic          op_q, op_d;
  logic [7:0]    byte_q, byte_d;
  logic [31:0]   wm_q, wm_d;
  logic [2:0]    bpr_q, bpr_d;
  logic [9:0]    ox_q, ox_d, oy_q, oy_d;
  logic [7:0]    col_q, col_d;
  logic          sc2_q, sc2_d;
  logic [2:0]    iss_q, iss_d, cap_q, cap_d;
  logic          rv_q, rv_d;
  logic [31:0]   row_q, row_d;
  logic [SW-1:0] srow_q, srow_d;
  logic [RW-1:0] r_q, r_d;
  logic          rep_q, rep_d;

  logic          ov_q, ov_d;
  logic [10:0]   oy_out_q, oy_out_d;
  logic [9:0]    ox_out_q, ox_out_d;
  logic [7:0]    col_out_q, col_out_d;
  logic [63:0]   mask_q, mask_d;
  logic          last_q, last_d;

  logic          in_fire, emit, re, we, last_now;
  logic [7:0]    rdata;
  logic [5:0]    w6;
  logic [31:0]   pix;
  logic [1:0]    slot;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign ptr_inc = (({1'b0, ptr_q} + 1'b1) == FB) ? '0 : ptr_q + 1'b1;
  assign w6 = (s_axis_tdata[37:32] > 6'(sbgr_pkg::MaxWidth)) ?
              6'(sbgr_pkg::MaxWidth) : s_axis_tdata[37:32];
  assign slot = 2'd3 - cap_q[1:0];
  assign emit = (state_q == S_OUT) && (!ov_q || m_axis_tready);
  assign last_now = (srow_q == LastSrc) && (!sc2_q || rep_q);
  assign re = (state_q == S_RD) && (iss_q < bpr_q);
  assign we = (state_q == S_LOAD);

  always_comb begin
    for (int c = 0; c < 32; c++) begin
      pix[c] = row_q[31-c] & wm_q[c];
    end
    for (int j = 0; j < 64; j++) begin
      if (sc2_q) begin
        mask_d[j] = pix[j/2];
      end else begin
        mask_d[j] = (j < 32) ? pix[j%32] : 1'b0;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    ptr_d   = ptr_q;
    op_d    = op_q;
    byte_d  = byte_q;
    wm_d    = wm_q;
    bpr_d   = bpr_q;
    ox_d    = ox_q;
    oy_d    = oy_q;
    col_d   = col_q;
    sc2_d   = sc2_q;
    iss_d   = iss_q;
    cap_d   = cap_q;
    rv_d    = re;
    row_d   = row_q;
    srow_d  = srow_q;
    r_d     = r_q;
    rep_d   = rep_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_d   = s_axis_tuser;
          ptr_d  = PW'((s_axis_tuser == sbgr_pkg::OpDraw) ?
                       s_axis_tdata[31:20] : s_axis_tdata[11:0]);
          byte_d = s_axis_tdata[19:12];
          for (int c = 0; c < 32; c++) begin
            wm_d[c] = (6'(c) < w6);
          end
          bpr_d  = 3'(({1'b0, w6} + 7'd7) >> 3);
          ox_d   = s_axis_tdata[47:38];
          oy_d   = s_axis_tdata[57:48];
          col_d  = s_axis_tdata[65:58];
          sc2_d  = (s_axis_tdata[67:66] == 2'd2);
          iss_d  = '0;
          cap_d  = '0;
          row_d  = '0;
          srow_d = '0;
          r_d    = '0;
          rep_d  = 1'b0;
          state_d = S_WRAP;
        end
      end
      S_WRAP: begin
        if ({1'b0, ptr_q} >= FB) begin
          ptr_d = ptr_q - FB[PW-1:0];
        end else if (op_q == sbgr_pkg::OpLoad) begin
          state_d = S_LOAD;
        end else begin
          state_d = S_RD;
        end
      end
      S_LOAD: begin
        state_d = S_IDLE;
      end
      S_RD: begin
        if (re) begin
          iss_d = iss_q + 1'b1;
          ptr_d = ptr_inc;
        end
        if (rv_q) begin
          row_d[{slot, 3'b000} +: 8] = rdata;
          cap_d = cap_q + 1'b1;
        end
        if (cap_d == bpr_q) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (emit) begin
          r_d = r_q + 1'b1;
          if (sc2_q && !rep_q) begin
            rep_d = 1'b1;
          end else begin
            rep_d = 1'b0;
            if (srow_q == LastSrc) begin
              state_d = S_IDLE;
            end else begin
              srow_d  = srow_q + 1'b1;
              iss_d   = '0;
              cap_d   = '0;
              row_d   = '0;
              state_d = S_RD;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ov_d      = ov_q;
    oy_out_d  = oy_out_q;
    ox_out_d  = ox_out_q;
    col_out_d = col_out_q;
    last_d    = last_q;
    if (emit) begin
      ov_d      = 1'b1;
      oy_out_d  = 11'(oy_q) + 11'(r_q);
      ox_out_d  = ox_q;
      col_out_d = col_q;
      last_d    = last_now;
    end else if (m_axis_tready) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      iss_q   <= '0;
      cap_q   <= '0;
      rv_q    <= 1'b0;
      srow_q  <= '0;
      r_q     <= '0;
      rep_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      iss_q   <= iss_d;
      cap_q   <= cap_d;
      rv_q    <= rv_d;
      srow_q  <= srow_d;
      r_q     <= r_d;
      rep_q   <= rep_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q     <= ptr_d;
    op_q      <= op_d;
    byte_q    <= byte_d;
    wm_q      <= wm_d;
    bpr_q     <= bpr_d;
    ox_q      <= ox_d;
    oy_q      <= oy_d;
    col_q     <= col_d;
    sc2_q     <= sc2_d;
    row_q     <= row_d;
    oy_out_q  <= oy_out_d;
    ox_out_q  <= ox_out_d;
    col_out_q <= col_out_d;
    last_q    <= last_d;
    if (emit) begin
      mask_q <= mask_d;
    end
  end

  sbgr_ram #(
    .Width (sbgr_pkg::ByteW),
    .Depth (FONT_BYTES)
  ) u_font (
    .clk_i   (clk_i),
    .we_i    (we),
    .re_i    (re),
    .addr_i  (ptr_q[AW-1:0]),
    .wdata_i (byte_q),
    .rdata_o (rdata)
  );

  assign m_axis_tvalid = ov_q;
  assign m_axis_tlast  = last_q;
  assign m_axis_tdata  = {3'b000, mask_q, col_out_q, ox_out_q, oy_out_q};

  a_cap_le_iss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cap_q <= iss_q) else $error("capture count ran ahead of reads");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(we && re)) else $error("font RAM read and write in one cycle");

  a_ptr_wrapped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD || state_q == S_LOAD) |-> ({1'b0, ptr_q} < FB))
    else $error("font pointer not wrapped");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && last_now) |=> (state_q == S_IDLE))
    else $error("last row emitted but sequencer still busy");

  a_bpr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD) |-> (bpr_q <= 3'd4))
    else $error("bytes per row out of range");

endmodule
